>>> hdl/mnp_pkg.sv
// ----------------------------------------------------------------------------
// mnp_pkg: shared types, constants and helpers of the metadata NAL packer
// Template and NAL limits, register codes, item and result layouts, and the
// CRC-32/MPEG-2 byte step.
// ----------------------------------------------------------------------------
package mnp_pkg;

  localparam int TEMPLATE_MAX = 256;
  localparam int NAL_CAPACITY = 512;

  localparam int BYTE_W     = 8;
  localparam int LVL_W      = 12;
  localparam int OFF_W      = 11;
  localparam int SIZE_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // template position holds 0 .. TEMPLATE_MAX
  localparam int POS_W = $clog2(TEMPLATE_MAX + 1);
  // NAL byte count holds 0 .. NAL_CAPACITY
  localparam int CNT_W = $clog2(NAL_CAPACITY + 1);
  // size clamp is done in the wider of the register and position widths
  localparam int SZC_W = (POS_W > SIZE_W) ? POS_W : SIZE_W;
  // bit position in the template; also holds offset + field span
  localparam int GW    = (POS_W + 3 > OFF_W + 1) ? POS_W + 3 : OFF_W + 1;

  localparam int FIELD_BITS = 36;
  localparam int SIZE_MIN   = 7;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0]       CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0]       CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [BYTE_W-1:0] NAL_HDR0 = 8'h7C;
  localparam logic [BYTE_W-1:0] NAL_HDR1 = 8'h01;
  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h03;
  localparam logic [LVL_W-1:0]  LVL_MAX  = 12'hFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATCH_OFFSET_PLAIN   = 3'd0,
    REG_PATCH_OFFSET_REFRESH = 3'd1,
    REG_SIZE_PLAIN           = 3'd2,
    REG_SIZE_REFRESH         = 3'd3,
    REG_MIN_LEVEL_CEILING    = 3'd4,
    REG_MAX_LEVEL_FLOOR      = 3'd5,
    REG_MAX_LEVEL_CEILING    = 3'd6,
    REG_AVG_LEVEL_FLOOR      = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    OP_METADATA = 1'b0,
    OP_TEMPLATE = 1'b1
  } op_t;

  typedef struct packed {
    logic [OFF_W-1:0]  patch_offset_plain;
    logic [OFF_W-1:0]  patch_offset_refresh;
    logic [SIZE_W-1:0] size_plain;
    logic [SIZE_W-1:0] size_refresh;
    logic [LVL_W-1:0]  min_level_ceiling;
    logic [LVL_W-1:0]  max_level_floor;
    logic [LVL_W-1:0]  max_level_ceiling;
    logic [LVL_W-1:0]  avg_level_floor;
  } cfg_regs_t;

  typedef struct packed {
    logic              op;
    logic [LVL_W-1:0]  min_level;
    logic [LVL_W-1:0]  max_level;
    logic [LVL_W-1:0]  avg_level;
    logic              new_scene;
    logic [BYTE_W-1:0] template_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              item_last;
    logic              frame_last;
    logic              overrun;
  } res_t;

  // up to two results written to the output queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [LVL_W-1:0] clamp_lvl(logic [LVL_W-1:0] v,
                                                 logic [LVL_W-1:0] lo,
                                                 logic [LVL_W-1:0] hi);
    logic [LVL_W-1:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [BYTE_W-1:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h00_0000};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/mnp_ifs.sv
// ----------------------------------------------------------------------------
// mnp channel interfaces
// Valid/ready channels for input items, result bytes and register writes.
// ----------------------------------------------------------------------------
interface mnp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [mnp_pkg::LVL_W-1:0]  min_level;
  logic [mnp_pkg::LVL_W-1:0]  max_level;
  logic [mnp_pkg::LVL_W-1:0]  avg_level;
  logic                       new_scene;
  logic [mnp_pkg::BYTE_W-1:0] template_byte;

  modport source (output valid, op, min_level, max_level, avg_level, new_scene,
                  template_byte, input ready);
  modport sink   (input valid, op, min_level, max_level, avg_level, new_scene,
                  template_byte, output ready);
endinterface

interface mnp_out_if;
  logic                       valid;
  logic                       ready;
  logic [mnp_pkg::BYTE_W-1:0] out_byte;
  logic                       item_last;
  logic                       frame_last;
  logic                       overrun;

  modport source (output valid, out_byte, item_last, frame_last, overrun, input ready);
  modport sink   (input valid, out_byte, item_last, frame_last, overrun, output ready);
endinterface

interface mnp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mnp_pkg::CFG_IDX_W-1:0]  index;
  logic [mnp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/mnp_cfg_regs.sv
// ----------------------------------------------------------------------------
// mnp_cfg_regs: configuration register file
// Takes one register write per cycle and holds the packer's settings.
// ----------------------------------------------------------------------------
module mnp_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  mnp_cfg_if.sink            cfg_ch,
  output mnp_pkg::cfg_regs_t regs
);

  mnp_pkg::cfg_regs_t regs_r;
  mnp_pkg::cfg_regs_t regs_nxt;

  assign cfg_ch.ready = 1'b1;
  assign regs         = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      unique case (mnp_pkg::cfg_idx_t'(cfg_ch.index))
        mnp_pkg::REG_PATCH_OFFSET_PLAIN:
          regs_nxt.patch_offset_plain = cfg_ch.data[mnp_pkg::OFF_W-1:0];
        mnp_pkg::REG_PATCH_OFFSET_REFRESH:
          regs_nxt.patch_offset_refresh = cfg_ch.data[mnp_pkg::OFF_W-1:0];
        mnp_pkg::REG_SIZE_PLAIN:
          regs_nxt.size_plain = cfg_ch.data[mnp_pkg::SIZE_W-1:0];
        mnp_pkg::REG_SIZE_REFRESH:
          regs_nxt.size_refresh = cfg_ch.data[mnp_pkg::SIZE_W-1:0];
        mnp_pkg::REG_MIN_LEVEL_CEILING:
          regs_nxt.min_level_ceiling = cfg_ch.data[mnp_pkg::LVL_W-1:0];
        mnp_pkg::REG_MAX_LEVEL_FLOOR:
          regs_nxt.max_level_floor = cfg_ch.data[mnp_pkg::LVL_W-1:0];
        mnp_pkg::REG_MAX_LEVEL_CEILING:
          regs_nxt.max_level_ceiling = cfg_ch.data[mnp_pkg::LVL_W-1:0];
        mnp_pkg::REG_AVG_LEVEL_FLOOR:
          regs_nxt.avg_level_floor = cfg_ch.data[mnp_pkg::LVL_W-1:0];
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.patch_offset_plain   <= '0;
      regs_r.patch_offset_refresh <= '0;
      regs_r.size_plain           <= mnp_pkg::SIZE_W'(mnp_pkg::SIZE_MIN);
      regs_r.size_refresh         <= mnp_pkg::SIZE_W'(mnp_pkg::SIZE_MIN);
      regs_r.min_level_ceiling    <= mnp_pkg::LVL_MAX;
      regs_r.max_level_floor      <= '0;
      regs_r.max_level_ceiling    <= mnp_pkg::LVL_MAX;
      regs_r.avg_level_floor      <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

>>> hdl/mnp_core.sv
// ----------------------------------------------------------------------------
// mnp_core: input register and per-byte packing logic
// Clamps and latches levels, patches template bytes, runs the CRC, swaps in
// the trailer, inserts escape bytes and guards the NAL capacity.
// ----------------------------------------------------------------------------
module mnp_core (
  input  logic               clk,
  input  logic               rst_n,
  mnp_in_if.sink             in_ch,
  input  mnp_pkg::cfg_regs_t regs,
  input  logic               room,
  output mnp_pkg::push_t     push
);

  localparam int POS_W  = mnp_pkg::POS_W;
  localparam int CNT_W  = mnp_pkg::CNT_W;
  localparam int SZC_W  = mnp_pkg::SZC_W;
  localparam int GW     = mnp_pkg::GW;
  localparam int LVL_W  = mnp_pkg::LVL_W;
  localparam int BYTE_W = mnp_pkg::BYTE_W;

  // input register
  logic              stg_valid_r, stg_valid_nxt;
  mnp_pkg::in_item_t stg_r;

  // frame state
  logic [LVL_W-1:0] min_held_r, min_held_nxt;
  logic [LVL_W-1:0] max_held_r, max_held_nxt;
  logic [LVL_W-1:0] avg_held_r, avg_held_nxt;
  logic             refresh_held_r, refresh_held_nxt;
  logic [POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [1:0]       zero_cnt_r, zero_cnt_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic             aborted_r, aborted_nxt;

  logic fire, accept, in_rdy;

  logic [mnp_pkg::SIZE_W-1:0] size_sel;
  logic [SZC_W-1:0]           size_wide;
  logic [POS_W-1:0]           sz;
  logic [mnp_pkg::OFF_W-1:0]  off;
  logic [GW-1:0]              offx, g;
  logic [5:0]                 fi;
  logic [3:0]                 fj;
  logic [LVL_W-1:0]           fv;
  logic [BYTE_W-1:0]          pb, b;
  logic                       in_crc, in_trl, no_frame, cap_hit, esc;
  logic [1:0]                 tidx;
  logic [LVL_W-1:0]           mx_c, hi_c;

  assign fire        = stg_valid_r && room;
  assign in_rdy      = !stg_valid_r || fire;
  assign in_ch.ready = in_rdy;
  assign accept      = in_ch.valid && in_rdy;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (accept) stg_valid_nxt = 1'b1;
    else if (fire) stg_valid_nxt = 1'b0;
  end

  // template geometry for the open frame
  always_comb begin
    size_sel = refresh_held_r ? regs.size_refresh : regs.size_plain;
    off      = refresh_held_r ? regs.patch_offset_refresh : regs.patch_offset_plain;
    if (SZC_W'(size_sel) < SZC_W'(mnp_pkg::SIZE_MIN)) size_wide = SZC_W'(mnp_pkg::SIZE_MIN);
    else if (SZC_W'(size_sel) > SZC_W'(mnp_pkg::TEMPLATE_MAX))
      size_wide = SZC_W'(mnp_pkg::TEMPLATE_MAX);
    else size_wide = SZC_W'(size_sel);
    sz = size_wide[POS_W-1:0];
  end

  // overwrite the bits that fall inside the 36-bit level field, MSB first
  always_comb begin
    offx = GW'(off);
    pb   = stg_r.template_byte;
    g    = '0;
    fi   = '0;
    fj   = '0;
    fv   = '0;
    for (int k = 0; k < 8; k++) begin
      g = GW'({byte_pos_r, 3'(k)});
      if (g >= offx && g < offx + GW'(mnp_pkg::FIELD_BITS)) begin
        fi = 6'(g - offx);
        if (fi < 6'd12) begin
          fj = 4'(fi);
          fv = min_held_r;
        end else if (fi < 6'd24) begin
          fj = 4'(fi - 6'd12);
          fv = max_held_r;
        end else begin
          fj = 4'(fi - 6'd24);
          fv = avg_held_r;
        end
        pb[7-k] = fv[4'd11 - fj];
      end
    end
  end

  always_comb begin
    in_crc = (byte_pos_r >= POS_W'(1)) && (byte_pos_r <= sz - POS_W'(6));
    in_trl = (byte_pos_r >= sz - POS_W'(5)) && (byte_pos_r <= sz - POS_W'(2));
    tidx   = 2'(byte_pos_r - (sz - POS_W'(5)));
    b      = pb;
    if (in_trl) begin
      unique case (tidx)
        2'd0:    b = crc_r[31:24];
        2'd1:    b = crc_r[23:16];
        2'd2:    b = crc_r[15:8];
        2'd3:    b = crc_r[7:0];
        default: b = pb;
      endcase
    end
    no_frame = (out_cnt_r == '0) || aborted_r || (byte_pos_r >= sz);
    cap_hit  = ({1'b0, out_cnt_r} + (CNT_W+1)'(1)) >= (CNT_W+1)'(mnp_pkg::NAL_CAPACITY);
    esc      = (zero_cnt_r == 2'd2) && (b <= mnp_pkg::ESC_BYTE);
    mx_c     = mnp_pkg::clamp_lvl(stg_r.max_level, regs.max_level_floor,
                                  regs.max_level_ceiling);
    hi_c     = (mx_c == '0) ? mnp_pkg::LVL_MAX : mx_c - LVL_W'(1);
  end

  always_comb begin
    min_held_nxt     = min_held_r;
    max_held_nxt     = max_held_r;
    avg_held_nxt     = avg_held_r;
    refresh_held_nxt = refresh_held_r;
    byte_pos_nxt     = byte_pos_r;
    crc_nxt          = crc_r;
    zero_cnt_nxt     = zero_cnt_r;
    out_cnt_nxt      = out_cnt_r;
    aborted_nxt      = aborted_r;
    push             = '0;
    if (fire) begin
      if (mnp_pkg::op_t'(stg_r.op) == mnp_pkg::OP_METADATA) begin
        min_held_nxt     = (stg_r.min_level > regs.min_level_ceiling) ?
                           regs.min_level_ceiling : stg_r.min_level;
        max_held_nxt     = mx_c;
        avg_held_nxt     = mnp_pkg::clamp_lvl(stg_r.avg_level, regs.avg_level_floor, hi_c);
        refresh_held_nxt = stg_r.new_scene;
        byte_pos_nxt     = '0;
        crc_nxt          = mnp_pkg::CRC_INIT;
        zero_cnt_nxt     = '0;
        aborted_nxt      = 1'b0;
        out_cnt_nxt      = CNT_W'(2);
        push.cnt         = 2'd2;
        push.r0          = '{out_byte: mnp_pkg::NAL_HDR0, item_last: 1'b0,
                             frame_last: 1'b0, overrun: 1'b0};
        push.r1          = '{out_byte: mnp_pkg::NAL_HDR1, item_last: 1'b1,
                             frame_last: 1'b0, overrun: 1'b0};
      end else if (no_frame) begin
        push.cnt = 2'd0;
      end else if (cap_hit) begin
        // abort the frame, report once
        aborted_nxt = 1'b1;
        push.cnt    = 2'd1;
        push.r0     = '{out_byte: '0, item_last: 1'b1, frame_last: 1'b1, overrun: 1'b1};
      end else begin
        if (in_crc) crc_nxt = mnp_pkg::crc_byte(crc_r, pb);
        byte_pos_nxt = byte_pos_r + POS_W'(1);
        if (esc) begin
          push.cnt    = 2'd2;
          push.r0     = '{out_byte: mnp_pkg::ESC_BYTE, item_last: 1'b0,
                          frame_last: 1'b0, overrun: 1'b0};
          push.r1     = '{out_byte: b, item_last: 1'b1,
                          frame_last: (byte_pos_r == sz - POS_W'(1)), overrun: 1'b0};
          out_cnt_nxt = out_cnt_r + CNT_W'(2);
        end else begin
          push.cnt    = 2'd1;
          push.r0     = '{out_byte: b, item_last: 1'b1,
                          frame_last: (byte_pos_r == sz - POS_W'(1)), overrun: 1'b0};
          out_cnt_nxt = out_cnt_r + CNT_W'(1);
        end
        if (b != '0) zero_cnt_nxt = 2'd0;
        else if (esc) zero_cnt_nxt = 2'd1;
        else if (zero_cnt_r < 2'd2) zero_cnt_nxt = zero_cnt_r + 2'd1;
        else zero_cnt_nxt = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r <= '{op: in_ch.op, min_level: in_ch.min_level, max_level: in_ch.max_level,
                 avg_level: in_ch.avg_level, new_scene: in_ch.new_scene,
                 template_byte: in_ch.template_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r    <= 1'b0;
      min_held_r     <= '0;
      max_held_r     <= '0;
      avg_held_r     <= '0;
      refresh_held_r <= 1'b0;
      byte_pos_r     <= '0;
      crc_r          <= mnp_pkg::CRC_INIT;
      zero_cnt_r     <= '0;
      out_cnt_r      <= '0;
      aborted_r      <= 1'b0;
    end else begin
      stg_valid_r    <= stg_valid_nxt;
      min_held_r     <= min_held_nxt;
      max_held_r     <= max_held_nxt;
      avg_held_r     <= avg_held_nxt;
      refresh_held_r <= refresh_held_nxt;
      byte_pos_r     <= byte_pos_nxt;
      crc_r          <= crc_nxt;
      zero_cnt_r     <= zero_cnt_nxt;
      out_cnt_r      <= out_cnt_nxt;
      aborted_r      <= aborted_nxt;
    end
  end

endmodule

>>> hdl/mnp_out_fifo.sv
// ----------------------------------------------------------------------------
// mnp_out_fifo: result byte queue
// Takes up to two results per cycle and hands out one per request.
// ----------------------------------------------------------------------------
module mnp_out_fifo (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mnp_pkg::push_t                     push,
  mnp_out_if.source                          out_ch,
  output logic [mnp_pkg::FIFO_CNT_W-1:0]     level
);

  localparam int PTR_W = mnp_pkg::FIFO_PTR_W;
  localparam int CW    = mnp_pkg::FIFO_CNT_W;

  mnp_pkg::res_t    mem_r [mnp_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    level_r, level_nxt;
  logic             pop;
  mnp_pkg::res_t    head;

  assign head              = mem_r[rd_ptr_r];
  assign out_ch.valid      = (level_r != '0);
  assign out_ch.out_byte   = head.out_byte;
  assign out_ch.item_last  = head.item_last;
  assign out_ch.frame_last = head.frame_last;
  assign out_ch.overrun    = head.overrun;
  assign level             = level_r;

  assign pop = out_ch.valid && out_ch.ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    level_nxt  = level_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_r + PTR_W'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

>>> hdl/metadata_nal_packer.sv
// ----------------------------------------------------------------------------
// metadata_nal_packer: luminance metadata NAL unit packer
// Patches levels into a streamed template, adds a CRC-32/MPEG-2 trailer, the
// NAL header and emulation prevention bytes, and guards the NAL capacity.
// ----------------------------------------------------------------------------
// A metadata request yields the two NAL header bytes; each template byte
// request inside an open frame yields its byte, preceded by a 0x03 when two
// zeros precede a byte of 3 or less, or a single overrun result once the NAL
// capacity is reached. A request waits in the input register and is then
// processed into a four-entry result queue; the block takes one request per
// cycle as long as the queue has room for two results. The result port moves
// one byte per cycle while the receiver is ready, so requests that yield two
// bytes hold it longer and that port sets the sustained rate. Register writes
// take effect once registered; there is no clearing pass after reset.
module metadata_nal_packer (
  input  logic      clk,
  input  logic      rst_n,
  mnp_in_if.sink    in_ch,
  mnp_out_if.source out_ch,
  mnp_cfg_if.sink   cfg_ch
);

  mnp_pkg::cfg_regs_t                 regs;
  mnp_pkg::push_t                     push;
  logic [mnp_pkg::FIFO_CNT_W-1:0]     level;
  logic                               room;

  assign room = level <= mnp_pkg::FIFO_CNT_W'(mnp_pkg::FIFO_DEPTH - 2);

  mnp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  mnp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .regs  (regs),
    .room  (room),
    .push  (push)
  );

  mnp_out_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .out_ch (out_ch),
    .level  (level)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= mnp_pkg::FIFO_CNT_W'(mnp_pkg::FIFO_DEPTH))
    else $error("result queue over depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> $past(level) <= mnp_pkg::FIFO_CNT_W'(mnp_pkg::FIFO_DEPTH) &&
                         room)
    else $error("results written without queue room");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> !push.r0.item_last && push.r1.item_last && !push.r0.frame_last)
    else $error("two-result request out of order");

  a_overrun_fields: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 && push.r0.overrun |-> push.cnt == 2'd1 && push.r0.frame_last &&
                                            push.r0.out_byte == '0)
    else $error("malformed overrun result");

endmodule

>>> tb/sv/metadata_nal_packer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// metadata_nal_packer_test: self-checking bench of the metadata NAL packer
// Drives metadata and template byte requests with random gaps, writes the
// registers between phases, and checks every result byte against a
// cycle-free prediction of the packed NAL unit.
// ----------------------------------------------------------------------------
module metadata_nal_packer_test;
  import mnp_pkg::*;

  // Holds the expected NAL bytes of every accepted request, oldest first.
  class nal_packer_scoreboard;
    cfg_regs_t        regs;
    logic [LVL_W-1:0] min_lvl, max_lvl, avg_lvl;
    bit               use_refresh;
    int unsigned      tpl_pos, zeros, nal_len;
    bit               dropped;
    logic [31:0]      crc;
    res_t             pending_bytes[$];
    int               errors;

    function new();
      regs.patch_offset_plain   = '0;
      regs.patch_offset_refresh = '0;
      regs.size_plain           = SIZE_W'(SIZE_MIN);
      regs.size_refresh         = SIZE_W'(SIZE_MIN);
      regs.min_level_ceiling    = LVL_MAX;
      regs.max_level_floor      = '0;
      regs.max_level_ceiling    = LVL_MAX;
      regs.avg_level_floor      = '0;
      min_lvl = '0;
      max_lvl = '0;
      avg_lvl = '0;
      use_refresh = 1'b0;
      tpl_pos = 0;
      zeros = 0;
      nal_len = 0;
      dropped = 1'b0;
      crc = CRC_INIT;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] word);
      case (idx)
        REG_PATCH_OFFSET_PLAIN:   regs.patch_offset_plain   = word[OFF_W-1:0];
        REG_PATCH_OFFSET_REFRESH: regs.patch_offset_refresh = word[OFF_W-1:0];
        REG_SIZE_PLAIN:           regs.size_plain           = word[SIZE_W-1:0];
        REG_SIZE_REFRESH:         regs.size_refresh         = word[SIZE_W-1:0];
        REG_MIN_LEVEL_CEILING:    regs.min_level_ceiling    = word[LVL_W-1:0];
        REG_MAX_LEVEL_FLOOR:      regs.max_level_floor      = word[LVL_W-1:0];
        REG_MAX_LEVEL_CEILING:    regs.max_level_ceiling    = word[LVL_W-1:0];
        REG_AVG_LEVEL_FLOOR:      regs.avg_level_floor      = word[LVL_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned frame_size(bit refresh);
      int unsigned s;
      s = 32'(refresh ? regs.size_refresh : regs.size_plain);
      if (s < SIZE_MIN) s = SIZE_MIN;
      if (s > TEMPLATE_MAX) s = TEMPLATE_MAX;
      return s;
    endfunction

    // when the bounds cross, a value below the lower bound gets the lower bound and any other the upper
    function logic [LVL_W-1:0] bound(logic [LVL_W-1:0] v, logic [LVL_W-1:0] lo,
                                     logic [LVL_W-1:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [BYTE_W-1:0] d);
      logic [31:0] r;
      logic        fb;
      r = c;
      for (int j = BYTE_W - 1; j >= 0; j--) begin
        fb = r[31] ^ d[j];
        r = {r[30:0], 1'b0};
        if (fb) r = r ^ CRC_POLY;
      end
      return r;
    endfunction

    // overlay the 36 level bits, MSB first, at bit offset off
    function logic [BYTE_W-1:0] patch(logic [BYTE_W-1:0] raw, int unsigned pos,
                                      int unsigned off);
      logic [BYTE_W-1:0] b;
      logic [LVL_W-1:0]  lvl;
      int unsigned       g, i;
      b = raw;
      for (int k = 0; k < BYTE_W; k++) begin
        g = pos * BYTE_W + k;
        if (g >= off && g < off + FIELD_BITS) begin
          i = g - off;
          lvl = (i < LVL_W) ? min_lvl : ((i < 2 * LVL_W) ? max_lvl : avg_lvl);
          b[BYTE_W-1-k] = lvl[LVL_W-1 - (i % LVL_W)];
        end
      end
      return b;
    endfunction

    function void emit(logic [BYTE_W-1:0] b, logic il, logic fl, logic ov);
      res_t r;
      r.out_byte   = b;
      r.item_last  = il;
      r.frame_last = fl;
      r.overrun    = ov;
      pending_bytes.push_back(r);
    endfunction

    // returns the number of result bytes the request causes
    function int note_request(in_item_t it);
      int unsigned       size, off, pos, hi, sh;
      logic [BYTE_W-1:0] b;
      int                n;
      n = 0;
      if (it.op == OP_METADATA) begin
        min_lvl = (it.min_level > regs.min_level_ceiling) ? regs.min_level_ceiling
                                                          : it.min_level;
        max_lvl = bound(it.max_level, regs.max_level_floor, regs.max_level_ceiling);
        hi = (max_lvl == 0) ? 32'(LVL_MAX) : 32'(max_lvl) - 1;
        avg_lvl = bound(it.avg_level, regs.avg_level_floor, hi[LVL_W-1:0]);
        use_refresh = it.new_scene;
        tpl_pos = 0;
        crc = CRC_INIT;
        zeros = 0;
        dropped = 1'b0;
        nal_len = 2;
        emit(NAL_HDR0, 1'b0, 1'b0, 1'b0);
        emit(NAL_HDR1, 1'b1, 1'b0, 1'b0);
        return 2;
      end
      size = frame_size(use_refresh);
      off = 32'(use_refresh ? regs.patch_offset_refresh : regs.patch_offset_plain);
      if (nal_len == 0 || dropped || tpl_pos >= size) return 0;
      if (nal_len + 1 >= NAL_CAPACITY) begin
        dropped = 1'b1;
        emit(8'h00, 1'b1, 1'b1, 1'b1);
        return 1;
      end
      pos = tpl_pos;
      b = patch(it.template_byte, pos, off);
      if (pos >= 1 && pos <= size - 6) begin
        crc = crc_step(crc, b);
      end else if (pos >= size - 5 && pos <= size - 2) begin
        // replace the trailer with the CRC, big-endian
        sh = 24 - 8 * (pos - (size - 5));
        b = BYTE_W'(crc >> sh);
      end
      if (zeros == 2 && b <= ESC_BYTE) begin
        emit(ESC_BYTE, 1'b0, 1'b0, 1'b0);
        n++;
        nal_len++;
        zeros = 0;
      end
      emit(b, 1'b1, pos == size - 1, 1'b0);
      n++;
      nal_len++;
      zeros = (b == 0) ? ((zeros < 2) ? zeros + 1 : 2) : 0;
      tpl_pos = pos + 1;
      return n;
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got byte %02h last %0b/%0b ovr %0b",
                 $time, got.out_byte, got.item_last, got.frame_last, got.overrun);
        return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch: expected byte %02h last %0b/%0b ovr %0b, got byte %02h last %0b/%0b ovr %0b",
                 $time, want.out_byte, want.item_last, want.frame_last, want.overrun,
                 got.out_byte, got.item_last, got.frame_last, got.overrun);
      end
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 34;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;      // no idling on either side while set
  int   hold_req;    // receiver hold-off length, picked up by the receiver
  int   productive;  // accepted requests that caused at least one result

  nal_packer_scoreboard sb = new();

  mnp_in_if  in_bus();
  mnp_out_if out_bus();
  mnp_cfg_if cfg_bus();

  metadata_nal_packer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: check accepted bytes, stall at random or for a long hold-off
  initial begin
    res_t got;
    int   hold_left;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got.out_byte   = out_bus.out_byte;
        got.item_last  = out_bus.item_last;
        got.frame_last = out_bus.frame_last;
        got.overrun    = out_bus.overrun;
        sb.check_result(got);
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic [LVL_W-1:0] rand_level();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return LVL_MAX;
    return LVL_W'($urandom_range(4095));
  endfunction

  // lean toward zeros and small bytes so escapes happen often
  function automatic logic [BYTE_W-1:0] rand_byte();
    int r;
    r = $urandom_range(99);
    if (r < 35) return 8'h00;
    if (r < 45) return BYTE_W'($urandom_range(1, 3));
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic in_item_t meta_levels(logic [LVL_W-1:0] mn, logic [LVL_W-1:0] mx,
                                           logic [LVL_W-1:0] av, logic refresh);
    in_item_t it;
    it.op            = OP_METADATA;
    it.min_level     = mn;
    it.max_level     = mx;
    it.avg_level     = av;
    it.new_scene     = refresh;
    it.template_byte = BYTE_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t tpl_item(logic [BYTE_W-1:0] b);
    in_item_t it;
    it.op            = OP_TEMPLATE;
    it.min_level     = LVL_W'($urandom);
    it.max_level     = LVL_W'($urandom);
    it.avg_level     = LVL_W'($urandom);
    it.new_scene     = 1'($urandom);
    it.template_byte = b;
    return it;
  endfunction

  task automatic offer_request(in_item_t it);
    in_bus.valid         <= 1'b1;
    in_bus.op            <= it.op;
    in_bus.min_level     <= it.min_level;
    in_bus.max_level     <= it.max_level;
    in_bus.avg_level     <= it.avg_level;
    in_bus.new_scene     <= it.new_scene;
    in_bus.template_byte <= it.template_byte;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (sb.note_request(it) > 0) productive++;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // drop valid, wait for every expected byte, then let the pipe empty
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val, int w);
    int unsigned           mask;
    logic [CFG_DATA_W-1:0] word;
    mask = (1 << w) - 1;
    // junk above the register width half of the time
    word = CFG_DATA_W'(($urandom_range(1) ? ($urandom & ~mask) : 0) | (val & mask));
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= word;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.set_reg(idx, word);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int unsigned off_plain, int unsigned off_refresh,
                           int unsigned sz_plain, int unsigned sz_refresh,
                           int unsigned min_ceil, int unsigned max_floor,
                           int unsigned max_ceil, int unsigned avg_floor);
    write_reg(REG_PATCH_OFFSET_PLAIN,   off_plain,   OFF_W);
    write_reg(REG_PATCH_OFFSET_REFRESH, off_refresh, OFF_W);
    write_reg(REG_SIZE_PLAIN,           sz_plain,    SIZE_W);
    write_reg(REG_SIZE_REFRESH,         sz_refresh,  SIZE_W);
    write_reg(REG_MIN_LEVEL_CEILING,    min_ceil,    LVL_W);
    write_reg(REG_MAX_LEVEL_FLOOR,      max_floor,   LVL_W);
    write_reg(REG_MAX_LEVEL_CEILING,    max_ceil,    LVL_W);
    write_reg(REG_AVG_LEVEL_FLOOR,      avg_floor,   LVL_W);
  endtask

  // mostly whole frames with random content, some cut short or run past
  // the end, and a few lone requests as noise
  task automatic run_frames(int quota, bit allow_long);
    int          goal, r, len;
    int unsigned size;
    bit          refresh;
    goal = productive + quota;
    while (productive < goal) begin
      r = $urandom_range(99);
      if (r < 8) begin
        if (r < 4) offer_request(tpl_item(rand_byte()));
        else offer_request(meta_levels(rand_level(), rand_level(), rand_level(),
                                       1'($urandom_range(1))));
      end else begin
        refresh = 1'($urandom_range(1));
        size = sb.frame_size(refresh);
        offer_request(meta_levels(rand_level(), rand_level(), rand_level(), refresh));
        r = $urandom_range(99);
        if (size > 64 && !allow_long) len = $urandom_range(1, 12);
        else if (r < 70) len = size;
        else if (r < 85) len = $urandom_range(1, size - 1);
        else len = size + $urandom_range(1, 3);
        repeat (len) offer_request(tpl_item(rand_byte()));
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] probe_bytes [16];
    probe_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'hFF, 8'h00, 8'h00,
                    8'h01, 8'h02, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44, 8'h00};
    steady = 1'b0;
    hold_req = 0;
    productive = 0;
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.op            <= OP_METADATA;
    in_bus.min_level     <= '0;
    in_bus.max_level     <= '0;
    in_bus.avg_level     <= '0;
    in_bus.new_scene     <= 1'b0;
    in_bus.template_byte <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= REG_PATCH_OFFSET_PLAIN;
    cfg_bus.data         <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // plain offset past the template: bytes pass unpatched, escapes visible
    configure(2047, 3, 16, 0, 4095, 0, 4095, 0);
    offer_request(tpl_item(8'hAA));                       // no frame open
    offer_request(meta_levels(12'hFFF, 12'h000, 12'hFFF, 1'b0));
    foreach (probe_bytes[i]) offer_request(tpl_item(probe_bytes[i]));
    offer_request(tpl_item(8'h5A));                       // past frame end
    offer_request(meta_levels(12'h000, 12'hFFF, 12'h000, 1'b1));
    offer_request(tpl_item(8'hFF));
    offer_request(tpl_item(8'h00));
    offer_request(meta_levels(12'h800, 12'h001, 12'hFFF, 1'b0));   // abandon frame
    offer_request(tpl_item(8'h5A));
    settle();

    configure($urandom_range(300), $urandom_range(300), $urandom_range(7, 40),
              $urandom_range(7, 40), 4095, 0, 4095, 0);
    hold_req = 150;
    run_frames(40, 1'b0);
    settle();

    // extreme bounds: crossed clamps, largest sizes, levels over the last byte
    configure(0, 2011, 511, 300, 0, 4095, 0, 4095);
    hold_req = 200;
    offer_request(meta_levels(rand_level(), rand_level(), rand_level(), 1'b1));
    repeat (257) offer_request(tpl_item(rand_byte()));
    run_frames(20, 1'b0);
    settle();

    configure(2047, 2040, 7, 6, $urandom_range(4095), $urandom_range(4095),
              $urandom_range(4095), $urandom_range(4095));
    run_frames(30, 1'b0);
    settle();

    configure($urandom_range(400), $urandom_range(400), $urandom_range(7, 48),
              $urandom_range(7, 48), $urandom_range(4095), $urandom_range(2048),
              $urandom_range(1024, 4095), $urandom_range(4095));
    steady = 1'b1;
    run_frames(30, 1'b0);
    steady = 1'b0;
    run_frames(30, 1'b0);
    settle();

    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
